// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset only.
`define ASSERT_ON(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Property checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== rtl/core/mrms_pkg.sv =====
// ----------------------------------------------------------------------------
// mrms_pkg
// Constants and controller/datapath command types for the modular range
// multiply sum block.
// ----------------------------------------------------------------------------
package mrms_pkg;

  // Prime modulus and Barrett constant floor(2^60 / prime).
  localparam logic [29:0] PRIME     = 30'd1000000007;
  localparam logic [30:0] BARRETT_MU = 31'd1152921496;

  localparam int DEF_MAX_LEAVES = 1024;
  localparam logic [10:0] LIU_RESET = 11'd1024;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic build_step;
    logic rd_en;
    logic mul_en;
    logic bar1_en;
    logic bar2_en;
    logic sub_en;
    logic upd_en;
    logic upd2_en;
    logic out_load;
  } mrms_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_build;
    logic range_empty;
    logic build_last;
    logic leaf_last;
    logic out_busy;
  } mrms_stat_t;

endpackage

// ===== rtl/core/mrms_dp.sv =====
// ----------------------------------------------------------------------------
// mrms_dp
// Datapath: leaf memory, modular multiply with Barrett reduction, running
// total sum and the output register.
// ----------------------------------------------------------------------------
module mrms_dp import mrms_pkg::*; #(
  parameter int MAX_LEAVES = DEF_MAX_LEAVES
) (
  input  logic        clk,
  input  logic        rst,
  input  mrms_cmd_t   cmd,
  output mrms_stat_t stat,
  input  logic        cfg_we,
  input  logic [10:0] cfg_data,
  input  logic        func,
  input  logic [10:0] range_low,
  input  logic [10:0] range_high,
  input  logic [29:0] factor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [29:0] total_sum
);

  localparam int AW = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;
  localparam int CW = $clog2(MAX_LEAVES + 1);
  localparam int IW = (CW > 11) ? CW : 11;
  localparam logic [IW-1:0] MAXI = IW'(MAX_LEAVES);

  logic [29:0] leaf_mem [MAX_LEAVES];

  logic [10:0]   liu;
  logic          func_r;
  logic [IW-1:0] hi_r;
  logic [IW-1:0] cur;
  logic          empty_r;
  logic [29:0]   f_r;
  logic [CW-1:0] baddr;
  logic [CW-1:0] n_lim;
  logic [29:0]   old_v;
  logic [59:0]   prod;
  logic [61:0]   qm;
  logic [31:0]   rem;
  logic [29:0]   sum;

  logic [IW-1:0] lo_c;
  logic [IW-1:0] hi_c;
  logic [IW-1:0] liu_w;
  logic [CW-1:0] n_c;
  logic [IW-1:0] cur_m1;
  logic [60:0]   qp;
  logic [30:0]   s_add;
  logic [30:0]   s_sub;

  // Clamp the range and the build size; form the Barrett and sum arithmetic.
  always_comb begin
    lo_c   = (range_low == 11'd0) ? IW'(1) : IW'(range_low);
    hi_c   = (IW'(range_high) > MAXI) ? MAXI : IW'(range_high);
    liu_w  = IW'(liu);
    n_c    = (liu == 11'd0) ? CW'(1) : ((liu_w > MAXI) ? CW'(MAX_LEAVES) : CW'(liu_w));
    cur_m1 = cur - IW'(1);
    qp     = qm[61:31] * PRIME;
    s_add  = {1'b0, sum} + {1'b0, rem[29:0]};
    s_sub  = (sum >= old_v) ? {1'b0, sum - old_v}
                            : ({1'b0, sum} + {1'b0, PRIME}) - {1'b0, old_v};
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      liu <= LIU_RESET;
    end else if (cfg_we) begin
      liu <= cfg_data;
    end
  end

  // Item registers, counters and arithmetic stages.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r  <= func;
      hi_r    <= hi_c;
      cur     <= lo_c;
      empty_r <= (lo_c > hi_c);
      f_r     <= (factor >= PRIME) ? factor - PRIME : factor;
      n_lim   <= n_c;
      baddr   <= '0;
      if (!func) begin
        sum <= 30'(n_c);
      end
    end
    if (cmd.build_step) begin
      baddr <= baddr + CW'(1);
    end
    if (cmd.mul_en) begin
      prod <= old_v * f_r;
    end
    if (cmd.bar1_en) begin
      qm <= prod[59:29] * BARRETT_MU;
    end
    if (cmd.bar2_en) begin
      rem <= prod[31:0] - qp[31:0];
    end
    if (cmd.sub_en) begin
      rem <= (rem >= {2'b00, PRIME}) ? rem - {2'b00, PRIME} : rem;
    end
    if (cmd.upd_en) begin
      sum <= (s_add >= {1'b0, PRIME}) ? 30'(s_add - {1'b0, PRIME}) : s_add[29:0];
    end
    if (cmd.upd2_en) begin
      sum <= s_sub[29:0];
      cur <= cur + IW'(1);
    end
  end

  // Leaf memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.build_step) begin
      leaf_mem[baddr[AW-1:0]] <= (baddr < n_lim) ? 30'd1 : 30'd0;
    end else if (cmd.upd_en) begin
      leaf_mem[cur_m1[AW-1:0]] <= rem[29:0];
    end
    if (cmd.rd_en) begin
      old_v <= leaf_mem[cur_m1[AW-1:0]];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      total_sum <= sum;
    end
  end

  always_comb begin
    stat.is_build    = !func_r;
    stat.range_empty = empty_r;
    stat.build_last  = (baddr == CW'(MAX_LEAVES - 1));
    stat.leaf_last   = (cur == hi_r);
    stat.out_busy    = out_valid && out_stall;
  end

endmodule

// ===== rtl/core/mrms_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrms_ctrl
// Controller: sequences builds and the per-leaf multiply steps.
// ----------------------------------------------------------------------------
module mrms_ctrl import mrms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  mrms_stat_t stat,
  output mrms_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_BUILD = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_BAR1  = 4'd5;
  localparam logic [3:0] S_BAR2  = 4'd6;
  localparam logic [3:0] S_SUB1  = 4'd7;
  localparam logic [3:0] S_SUB2  = 4'd8;
  localparam logic [3:0] S_UPD   = 4'd9;
  localparam logic [3:0] S_UPD2  = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.is_build) begin
          state_next = S_BUILD;
        end else if (stat.range_empty) begin
          state_next = S_FIN;
        end else begin
          state_next = S_RD;
        end
      end
      S_BUILD: begin
        cmd.build_step = 1'b1;
        if (stat.build_last) begin
          state_next = S_FIN;
        end
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_BAR1;
      end
      S_BAR1: begin
        cmd.bar1_en = 1'b1;
        state_next  = S_BAR2;
      end
      S_BAR2: begin
        cmd.bar2_en = 1'b1;
        state_next  = S_SUB1;
      end
      S_SUB1: begin
        cmd.sub_en = 1'b1;
        state_next = S_SUB2;
      end
      S_SUB2: begin
        cmd.sub_en = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd_en = 1'b1;
        state_next = S_UPD2;
      end
      S_UPD2: begin
        cmd.upd2_en = 1'b1;
        state_next  = stat.leaf_last ? S_FIN : S_RD;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/modular_range_multiply_sum_tree_top.sv =====
// ----------------------------------------------------------------------------
// modular_range_multiply_sum_tree_top
// Leaf values modulo 1000000007 with range multiply and total sum.
// ----------------------------------------------------------------------------
// Channel  | Handshake            | Payload
// in       | in_valid / in_stall  | func, range_low, range_high, factor
// out      | out_valid / out_stall| total_sum
// cfg      | cfg_valid / cfg_ready| leaves_in_use
//
// A build writes every leaf of the memory, one memory write per leaf.
// A multiply works through the leaves of the clamped range one at a time, each
// in the read, multiply, Barrett reduction, subtract and update steps.
// An empty range goes straight to the result. Reset is synchronous;
// leaf memory is not cleared and must be built before the first multiply.
// A stalled result holds the next finished item until it is taken.
// ----------------------------------------------------------------------------
module modular_range_multiply_sum_tree_top import mrms_pkg::*; #(
  parameter int MAX_LEAVES = DEF_MAX_LEAVES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] leaves_in_use,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [10:0] range_low,
  input  logic [10:0] range_high,
  input  logic [29:0] factor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [29:0] total_sum
);

  mrms_cmd_t  cmd;
  mrms_stat_t stat;

  assign cfg_ready = 1'b1;

  mrms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mrms_dp #(.MAX_LEAVES(MAX_LEAVES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (leaves_in_use),
    .func       (func),
    .range_low  (range_low),
    .range_high (range_high),
    .factor     (factor),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .total_sum  (total_sum)
  );

endmodule

// ===== rtl/core/mrms_chk.sv =====
// ----------------------------------------------------------------------------
// mrms_chk
// Port-level checks of the modular range multiply sum block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrms_chk import mrms_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [29:0] total_sum
);

  // A stalled result stays offered.
  `ASSERT_ON(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid)

  // Every offered sum is reduced below the prime.
  `ASSERT_ON(a_sum_reduced, clk, rst, out_valid |-> total_sum < PRIME)

  // Reset leaves no result pending.
  `ASSERT_ALWAYS(a_rst_clear, clk, rst |=> !out_valid)

  // A transfer in cannot be followed by another in the next cycle.
  `ASSERT_ON(a_in_gap, clk, rst, in_valid && !in_stall |=> in_stall)

endmodule

bind modular_range_multiply_sum_tree_top mrms_chk u_mrms_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .total_sum (total_sum)
);
